/* hdl/counting_semaphore_wait_queue_unit_macros.svh */
// Assertion helpers shared by the semaphore unit.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define CSQ_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/csq_pkg.sv */
package csq_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INIT_W   = 16;
    localparam int COUNT_W  = 18;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TID_W       = 8;

    // Saturation point of the signed count
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

    // Request kinds as they arrive on tuser
    localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

    // Internal operation after classification
    typedef enum logic [1:0] {
        OP_WAIT,
        OP_SIGNAL,
        OP_CLOSE,
        OP_NOP
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK             = 2'd0,
        STATUS_BLOCKED        = 2'd1,
        STATUS_REFUSED_CLOSED = 2'd2,
        STATUS_REFUSED_FULL   = 2'd3
    } status_t;

    // Control part of a queued command (thread id travels beside it)
    typedef struct packed {
        op_t  op;
        logic caller_closed;
    } cmd_ctl_t;

    localparam int CMD_CTL_W = $bits(cmd_ctl_t);

endpackage

/* hdl/csq_front.sv */
module csq_front #(
    parameter int TID_W = csq_pkg::DEF_TID_W,
    parameter int IN_W  = ((TID_W + 8) / 8) * 8
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // thread_id, caller_closed
    input  logic [csq_pkg::KIND_W-1:0] s_tuser,   // kind
    input  logic                       fifo_full,
    output logic                       push,
    output csq_pkg::cmd_ctl_t          push_ctl,
    output logic [TID_W-1:0]           push_tid
);

    // Take a transaction whenever the command queue has room
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    // Unpack payload
    assign push_tid = s_tdata[TID_W-1:0];

    // Classify request kind
    always_comb
    begin
        push_ctl.caller_closed = s_tdata[TID_W];
        case (s_tuser)
            csq_pkg::KIND_WAIT:   push_ctl.op = csq_pkg::OP_WAIT;
            csq_pkg::KIND_SIGNAL: push_ctl.op = csq_pkg::OP_SIGNAL;
            csq_pkg::KIND_CLOSE:  push_ctl.op = csq_pkg::OP_CLOSE;
            default:              push_ctl.op = csq_pkg::OP_NOP;
        endcase
    end

endmodule

/* hdl/csq_cmd_fifo.sv */
module csq_cmd_fifo #(
    parameter int DATA_W = csq_pkg::CMD_CTL_W + csq_pkg::DEF_TID_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] pop_data
);

    // Two entries: enough to pass one command per cycle while the back end is not stalled
    logic [DATA_W-1:0] store_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/csq_back.sv */
`include "counting_semaphore_wait_queue_unit_macros.svh"

module csq_back #(
    parameter int QUEUE_DEPTH = csq_pkg::DEF_QUEUE_DEPTH,
    parameter int TID_W       = csq_pkg::DEF_TID_W,
    parameter int OUT_W       = ((TID_W + 11) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  csq_pkg::cmd_ctl_t          cmd_ctl,
    input  logic [TID_W-1:0]           cmd_tid,
    output logic                       cmd_pop,
    input  logic                       cfg_we,
    input  logic [csq_pkg::INIT_W-1:0] cfg_wdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tlast
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W = csq_pkg::COUNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                              state_reg, state_next;
    logic signed [COUNT_W-1:0]           count_reg, count_next;
    logic [csq_pkg::INIT_W-1:0]          init_reg, init_next;
    logic [PTR_W-1:0]                    head_reg, head_next;
    logic [PTR_W-1:0]                    tail_reg, tail_next;
    logic [OCC_W-1:0]                    occ_reg, occ_next;
    logic                                out_valid_reg, out_valid_next;
    csq_pkg::status_t                    out_status_reg, out_status_next;
    logic                                out_rvalid_reg, out_rvalid_next;
    logic [TID_W-1:0]                    out_thread_reg, out_thread_next;
    logic                                out_by_close_reg, out_by_close_next;
    logic                                out_last_reg, out_last_next;

    // Waiter memory, read data always tracks the entry at head
    logic [TID_W-1:0]                    waiter_mem [QUEUE_DEPTH];
    logic [TID_W-1:0]                    rd_data_reg;
    logic                                mem_we;

    logic                                can_emit;
    logic                                count_pos;
    logic signed [COUNT_W-1:0]           count_dec;
    logic signed [COUNT_W-1:0]           count_inc;
    logic                                inc_le_zero;
    logic                                queue_full;
    logic [PTR_W-1:0]                    head_inc;
    logic [PTR_W-1:0]                    tail_inc;
    logic signed [COUNT_W-1:0]           count_reload;
    logic signed [COUNT_W-1:0]           occ_ext;

    // Count and pointer helpers
    assign count_pos    = !count_reg[COUNT_W-1] && (count_reg != '0);
    assign count_dec    = count_reg - COUNT_W'(1);
    assign count_inc    = (count_reg == csq_pkg::COUNT_MAX) ? count_reg
                                                             : count_reg + COUNT_W'(1);
    assign inc_le_zero  = count_inc[COUNT_W-1] || (count_inc == '0);
    assign queue_full   = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign head_inc     = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc     = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
    assign count_reload = $signed({{(COUNT_W - csq_pkg::INIT_W){1'b0}}, init_reg});
    assign occ_ext      = $signed({{(COUNT_W - OCC_W){1'b0}}, occ_reg});
    assign can_emit     = !out_valid_reg || m_tready;

    // Command execution
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        init_next         = cfg_we ? cfg_wdata : init_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        occ_next          = occ_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_status_next   = out_status_reg;
        out_rvalid_next   = out_rvalid_reg;
        out_thread_next   = out_thread_reg;
        out_by_close_next = out_by_close_reg;
        out_last_next     = out_last_reg;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && can_emit)
                begin
                    cmd_pop           = 1'b1;
                    out_valid_next    = 1'b1;
                    out_status_next   = csq_pkg::STATUS_OK;
                    out_rvalid_next   = 1'b0;
                    out_thread_next   = '0;
                    out_by_close_next = 1'b0;
                    out_last_next     = 1'b1;
                    case (cmd_ctl.op)
                        csq_pkg::OP_WAIT:
                        begin
                            if (count_pos)
                            begin
                                count_next = count_dec;
                            end
                            else if (cmd_ctl.caller_closed)
                            begin
                                out_status_next = csq_pkg::STATUS_REFUSED_CLOSED;
                            end
                            else if (queue_full)
                            begin
                                out_status_next = csq_pkg::STATUS_REFUSED_FULL;
                            end
                            else
                            begin
                                count_next      = count_dec;
                                mem_we          = 1'b1;
                                tail_next       = tail_inc;
                                occ_next        = occ_reg + OCC_W'(1);
                                out_status_next = csq_pkg::STATUS_BLOCKED;
                            end
                        end
                        csq_pkg::OP_SIGNAL:
                        begin
                            count_next = count_inc;
                            if (inc_le_zero && (occ_reg != '0))
                            begin
                                head_next       = head_inc;
                                occ_next        = occ_reg - OCC_W'(1);
                                out_rvalid_next = 1'b1;
                                out_thread_next = rd_data_reg;
                            end
                        end
                        csq_pkg::OP_CLOSE:
                        begin
                            if (occ_reg == '0)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = count_reload;
                            end
                            else
                            begin
                                // Releases go out one per cycle from the drain state while the output is not stalled
                                out_valid_next = 1'b0;
                                state_next     = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (can_emit)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = csq_pkg::STATUS_OK;
                    out_rvalid_next   = 1'b1;
                    out_thread_next   = rd_data_reg;
                    out_by_close_next = 1'b1;
                    out_last_next     = (occ_reg == OCC_W'(1));
                    head_next         = head_inc;
                    occ_next          = occ_reg - OCC_W'(1);
                    if (occ_reg == OCC_W'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = count_reload;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            init_reg         <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            occ_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= csq_pkg::STATUS_OK;
            out_rvalid_reg   <= 1'b0;
            out_thread_reg   <= '0;
            out_by_close_reg <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            init_reg         <= init_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            occ_reg          <= occ_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_rvalid_reg   <= out_rvalid_next;
            out_thread_reg   <= out_thread_next;
            out_by_close_reg <= out_by_close_next;
            out_last_reg     <= out_last_next;
        end
    end

    // Waiter memory: write at tail, registered read at next head with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            waiter_mem[tail_reg] <= cmd_tid;
        end
        if (mem_we && (tail_reg == head_next))
        begin
            rd_data_reg <= cmd_tid;
        end
        else
        begin
            rd_data_reg <= waiter_mem[head_next];
        end
    end

    // Output port
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_by_close_reg, out_thread_reg, out_rvalid_reg,
                              out_status_reg});

    // Checks
    `CSQ_ASSERT_NEVER(a_occ_bound, occ_reg > OCC_W'(QUEUE_DEPTH), "queue occupancy overflow")
    `CSQ_ASSERT(a_count_matches_queue, (state_reg == ST_IDLE) |-> (count_reg[COUNT_W-1] ? ((occ_ext + count_reg) == '0) : (occ_reg == '0)), "occupancy differs from negative count")
    `CSQ_ASSERT(a_drain_nonempty, (state_reg == ST_DRAIN) |-> (occ_reg != '0), "drain with empty queue")
    `CSQ_ASSERT(a_block_enqueues, (cmd_pop && mem_we) |=> (occ_reg == $past(occ_reg) + OCC_W'(1)), "blocked wait did not enqueue")

endmodule

/* hdl/counting_semaphore_wait_queue_unit.sv */
// A request is held in the command queue; its result is then registered on m_tvalid.
// Throughput: one wait, signal or unused-kind request per cycle while m_tready does not
// stall the output; a close drains the queued waiters one release at a time (a single
// result if the queue is empty), bound by the single read port of the waiter memory.
// Reset (rst_n, async, active low): count and initial_count to 0, queue empty,
// command queue and output register empty; no clearing pass, ready right after reset.
module counting_semaphore_wait_queue_unit #(
    parameter int QUEUE_DEPTH     = csq_pkg::DEF_QUEUE_DEPTH,
    parameter int THREAD_ID_WIDTH = csq_pkg::DEF_TID_W
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((THREAD_ID_WIDTH + 8) / 8) * 8-1:0]  s_tdata,  // thread_id, caller_closed
    input  logic [csq_pkg::KIND_W-1:0]                  s_tuser,  // kind
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((THREAD_ID_WIDTH + 11) / 8) * 8-1:0] m_tdata,  // status, released_valid,
                                                                  // released_thread,
                                                                  // released_by_close
    output logic                                        m_tlast,  // last
    input  logic                                        cfg_we,
    input  logic [csq_pkg::INIT_W-1:0]                  cfg_wdata // initial_count
);

    localparam int IN_W  = ((THREAD_ID_WIDTH + 8) / 8) * 8;
    localparam int OUT_W = ((THREAD_ID_WIDTH + 11) / 8) * 8;
    localparam int CMD_W = csq_pkg::CMD_CTL_W + THREAD_ID_WIDTH;

    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       push;
    csq_pkg::cmd_ctl_t          push_ctl;
    logic [THREAD_ID_WIDTH-1:0] push_tid;
    logic                       pop;
    logic [CMD_W-1:0]           pop_data;
    csq_pkg::cmd_ctl_t          cmd_ctl;
    logic [THREAD_ID_WIDTH-1:0] cmd_tid;

    // Front: accept and classify requests
    csq_front #(
        .TID_W (THREAD_ID_WIDTH),
        .IN_W  (IN_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_tid  (push_tid)
    );

    // Command queue between front and back
    csq_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_tid, push_ctl}),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .pop_data  (pop_data)
    );

    assign cmd_ctl = pop_data[csq_pkg::CMD_CTL_W-1:0];
    assign cmd_tid = pop_data[CMD_W-1:csq_pkg::CMD_CTL_W];

    // Back: semaphore count, waiter queue and result register
    csq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TID_W       (THREAD_ID_WIDTH),
        .OUT_W       (OUT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!fifo_empty),
        .cmd_ctl   (cmd_ctl),
        .cmd_tid   (cmd_tid),
        .cmd_pop   (pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
